// ===== hw/rtl/sdomc_pkg.sv =====
// Shared types, codes and constants of the SDO motor client.
// Depends on nothing; every other file of the block imports it.
package sdomc_pkg;

   // Command kinds of a command word
   localparam logic [3:0] KIND_SAVE       = 4'd0;
   localparam logic [3:0] KIND_CTRL_TYPE  = 4'd1;
   localparam logic [3:0] KIND_ACCEL_UNIT = 4'd2;
   localparam logic [3:0] KIND_SPEED_UNIT = 4'd3;
   localparam logic [3:0] KIND_MAX_SPEED  = 4'd4;
   localparam logic [3:0] KIND_SPEED      = 4'd5;
   localparam logic [3:0] KIND_POS_TYPE   = 4'd6;
   localparam logic [3:0] KIND_RESET_POS  = 4'd7;
   localparam logic [3:0] KIND_TARGET     = 4'd8;
   localparam logic [3:0] KIND_RD_FAULT   = 4'd9;
   localparam logic [3:0] KIND_RD_LOCKED  = 4'd10;
   localparam logic [3:0] KIND_RD_SPEED   = 4'd11;
   localparam logic [3:0] KIND_RD_POS     = 4'd12;

   // Request type
   localparam logic REQ_SEND   = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // SDO command specifiers
   localparam logic [7:0] CS_WRITE_1B = 8'h2F;
   localparam logic [7:0] CS_WRITE_4B = 8'h23;
   localparam logic [7:0] CS_READ     = 8'h40;
   localparam logic [7:0] CS_WR_ACK   = 8'h60;
   localparam logic [7:0] CS_RD_1B    = 8'h4F;
   localparam logic [7:0] CS_RD_2B    = 8'h4B;
   localparam logic [7:0] CS_RD_3B    = 8'h47;
   localparam logic [7:0] CS_RD_4B    = 8'h43;
   localparam logic [7:0] CS_ABORT    = 8'h80;

   // Object indices
   localparam logic [15:0] IDX_SAVE      = 16'h1010;
   localparam logic [15:0] IDX_CTRL_TYPE = 16'h2000;
   localparam logic [15:0] IDX_SPEED     = 16'h2001;
   localparam logic [15:0] IDX_POS_TYPE  = 16'h2002;
   localparam logic [15:0] IDX_TARGET    = 16'h2003;
   localparam logic [15:0] IDX_MAX_SPEED = 16'h2008;
   localparam logic [15:0] IDX_SPD_UNIT  = 16'h200A;
   localparam logic [15:0] IDX_ACC_UNIT  = 16'h200B;
   localparam logic [15:0] IDX_RESET_POS = 16'h200F;
   localparam logic [15:0] IDX_POSITION  = 16'h2105;
   localparam logic [15:0] IDX_RD_SPEED  = 16'h210A;
   localparam logic [15:0] IDX_LOCKED    = 16'h2111;
   localparam logic [15:0] IDX_FAULT     = 16'h2112;

   localparam logic [7:0]  SUB_SAVE   = 8'h01;
   localparam logic [31:0] SAVE_MAGIC = 32'h6576_6173;  // "save"

   localparam logic [10:0] TX_ID_BASE    = 11'h600;
   localparam logic [6:0]  NODE_ID_RESET = 7'd9;

   // Link status codes
   localparam logic [1:0] ST_READY  = 2'd0;
   localparam logic [1:0] ST_ERROR  = 2'd1;
   localparam logic [1:0] ST_LOCKED = 2'd2;
   localparam logic [1:0] ST_FAULT  = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [3:0]         cmd_kind;
      logic signed [31:0] cmd_value;
      logic [63:0]        rx_frame;
   } req_word_type;

   typedef struct packed {
      logic               tx_valid;
      logic [10:0]        tx_can_id;
      logic [63:0]        tx_data;
      logic [1:0]         link_status;
      logic signed [31:0] motor_position;
      logic signed [31:0] motor_speed;
      logic [31:0]        abort_code;
      logic               abort_seen;
   } rsp_word_type;

   // Request frame and its side effects on the kept state
   typedef struct packed {
      logic        valid;
      logic [63:0] data;
      logic        load_speed;
      logic        clear_pos;
   } tx_build_type;

   // Kept state after decoding a received frame
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] position;
      logic [31:0] speed;
      logic        abort_seen;
      logic [31:0] abort_code;
   } rx_update_type;

   function automatic logic [63:0] sdo_frame(input logic [7:0] cs, input logic [15:0] idx,
                                             input logic [7:0] sub, input logic [31:0] data);
      sdo_frame = {data, sub, idx, cs};
   endfunction

endpackage

// ===== hw/rtl/sdomc_tx_build.sv =====
// Request frame builder: maps a command kind and value to an SDO request.
// Depends on sdomc_pkg.
module sdomc_tx_build
   import sdomc_pkg::*;
(
   input  logic [3:0]  cmd_kind,
   input  logic [31:0] cmd_value,
   output tx_build_type tx
);

   always_comb begin
      tx = '0;
      tx.valid = 1'b1;
      unique case (cmd_kind)
         KIND_SAVE:       tx.data = sdo_frame(CS_WRITE_4B, IDX_SAVE, SUB_SAVE, SAVE_MAGIC);
         KIND_CTRL_TYPE:  tx.data = sdo_frame(CS_WRITE_1B, IDX_CTRL_TYPE, 8'h00,
                                              {24'h0, cmd_value[7:0]});
         KIND_ACCEL_UNIT: tx.data = sdo_frame(CS_WRITE_1B, IDX_ACC_UNIT, 8'h00,
                                              {24'h0, cmd_value[7:0]});
         KIND_SPEED_UNIT: tx.data = sdo_frame(CS_WRITE_1B, IDX_SPD_UNIT, 8'h00,
                                              {24'h0, cmd_value[7:0]});
         KIND_MAX_SPEED:  tx.data = sdo_frame(CS_WRITE_4B, IDX_MAX_SPEED, 8'h00,
                                              {16'h0, cmd_value[15:0]});
         KIND_SPEED: begin
            tx.data       = sdo_frame(CS_WRITE_4B, IDX_SPEED, 8'h00, cmd_value);
            tx.load_speed = 1'b1;
         end
         KIND_POS_TYPE:   tx.data = sdo_frame(CS_WRITE_1B, IDX_POS_TYPE, 8'h00,
                                              {24'h0, cmd_value[7:0]});
         KIND_RESET_POS: begin
            tx.data      = sdo_frame(CS_WRITE_4B, IDX_RESET_POS, 8'h00, 32'h0);
            tx.clear_pos = 1'b1;
         end
         KIND_TARGET:     tx.data = sdo_frame(CS_WRITE_4B, IDX_TARGET, 8'h00, cmd_value);
         KIND_RD_FAULT:   tx.data = sdo_frame(CS_READ, IDX_FAULT, 8'h00, 32'h0);
         KIND_RD_LOCKED:  tx.data = sdo_frame(CS_READ, IDX_LOCKED, 8'h00, 32'h0);
         KIND_RD_SPEED:   tx.data = sdo_frame(CS_READ, IDX_RD_SPEED, 8'h00, 32'h0);
         KIND_RD_POS:     tx.data = sdo_frame(CS_READ, IDX_POSITION, 8'h00, 32'h0);
         default:         tx.valid = 1'b0;
      endcase
   end

endmodule

// ===== hw/rtl/sdomc_rx_decode.sv =====
// Received frame decoder: updates kept status, position and speed from one
// SDO response or abort. Depends on sdomc_pkg.
module sdomc_rx_decode
   import sdomc_pkg::*;
(
   input  logic [63:0]   rx_frame,
   input  logic [1:0]    status,
   input  logic [31:0]   position,
   input  logic [31:0]   speed,
   output rx_update_type upd
);

   logic [7:0]  cs;
   logic [15:0] idx;
   logic [7:0]  sub;
   logic [31:0] mask;
   logic [31:0] data;
   logic        is_read;

   assign cs  = rx_frame[7:0];
   assign idx = rx_frame[23:8];
   assign sub = rx_frame[31:24];

   always_comb begin
      is_read = 1'b1;
      unique case (cs)
         CS_RD_1B: mask = 32'h0000_00FF;
         CS_RD_2B: mask = 32'h0000_FFFF;
         CS_RD_3B: mask = 32'h00FF_FFFF;
         CS_RD_4B: mask = 32'hFFFF_FFFF;
         default: begin
            mask    = 32'h0;
            is_read = 1'b0;
         end
      endcase
   end

   assign data = rx_frame[63:32] & mask;

   always_comb begin
      upd            = '0;
      upd.status     = status;
      upd.position   = position;
      upd.speed      = speed;
      if (cs == CS_WR_ACK) begin
         unique case (idx)
            IDX_SAVE: if (sub == SUB_SAVE) upd.status = ST_READY;
            IDX_CTRL_TYPE, IDX_SPEED, IDX_POS_TYPE, IDX_TARGET,
            IDX_MAX_SPEED, IDX_SPD_UNIT, IDX_ACC_UNIT, IDX_RESET_POS:
               upd.status = ST_READY;
            default: upd.status = ST_ERROR;
         endcase
      end else if (is_read) begin
         unique case (idx)
            IDX_POSITION: begin
               upd.position = data;
               upd.status   = ST_READY;
            end
            IDX_RD_SPEED: begin
               upd.speed  = data;
               upd.status = ST_READY;
            end
            IDX_LOCKED: if (data != 32'h0) upd.status = ST_LOCKED;
            IDX_FAULT:  if (data != 32'h0) upd.status = ST_FAULT;
            default:    upd.status = ST_ERROR;
         endcase
      end else if (cs == CS_ABORT) begin
         upd.status     = ST_ERROR;
         upd.abort_seen = 1'b1;
         upd.abort_code = rx_frame[63:32];
      end else begin
         upd.status = ST_ERROR;
      end
   end

endmodule

// ===== hw/rtl/sdo_motor_client_unit.sv =====
// Top level of the SDO motor client: input register, frame build/decode,
// kept motor state and result register. Depends on sdomc_pkg and submodules.
//
// Usage:
//  - req_ channel: one word per accepted edge (req_valid high, req_stall low).
//    req_type selects between building a request frame from cmd_kind and
//    cmd_value, or decoding a received frame in rx_frame.
//  - rsp_ channel: exactly one result word per request word, in order. It
//    carries the request frame (tx_valid, tx_can_id, tx_data), the kept
//    status, position and speed after this word, and any abort code.
//  - csr_ port: csr_write_en writes the 7-bit node id; write it only while
//    the block is idle.
// Path: an accepted word is held in the input register, then moves into the result
// register, where rsp_valid rises. Throughput is one word per cycle while rsp_stall
// is low: one pass of decode logic between the input and result registers, and the
// kept state updates as a word moves on, so the next sees it.
// Reset (synchronous, active high) empties both registers, sets status to
// ready, clears position and speed, and sets the node id to 9.
// When the receiver stalls, the result word holds; the input register takes one
// more word, then req_stall follows rsp_stall while both registers are full.
module sdo_motor_client_unit
   import sdomc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write_en,
   input  logic [6:0]   csr_write_data
);

   // Input register
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff, s1_word_in;
   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   // Kept state
   logic [1:0]   status_ff, status_in;
   logic [31:0]  position_ff, position_in;
   logic [31:0]  speed_ff, speed_in;
   logic [6:0]   node_id_ff, node_id_in;

   logic          advance;
   logic          req_take;
   tx_build_type  tx;
   rx_update_type rx;

   // Move the held word on when the result register is empty or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   sdomc_tx_build u_tx_build (
      .cmd_kind  (s1_word_ff.cmd_kind),
      .cmd_value (s1_word_ff.cmd_value),
      .tx        (tx)
   );

   sdomc_rx_decode u_rx_decode (
      .rx_frame (s1_word_ff.rx_frame),
      .status   (status_ff),
      .position (position_ff),
      .speed    (speed_ff),
      .upd      (rx)
   );

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_word_in  = req_take ? req_word : s1_word_ff;
      node_id_in  = csr_write_en ? csr_write_data : node_id_ff;

      // Next kept state; apply only when the word advances
      status_in   = status_ff;
      position_in = position_ff;
      speed_in    = speed_ff;
      rsp_word_in = '0;
      if (s1_word_ff.req_type == REQ_SEND) begin
         if (tx.valid) begin
            status_in = ST_READY;
            if (tx.load_speed) speed_in = s1_word_ff.cmd_value;
            if (tx.clear_pos)  position_in = 32'h0;
            rsp_word_in.tx_valid  = 1'b1;
            rsp_word_in.tx_can_id = TX_ID_BASE + {4'h0, node_id_ff};
            rsp_word_in.tx_data   = tx.data;
         end
      end else begin
         status_in   = rx.status;
         position_in = rx.position;
         speed_in    = rx.speed;
         rsp_word_in.abort_seen = rx.abort_seen;
         rsp_word_in.abort_code = rx.abort_code;
      end
      rsp_word_in.link_status    = status_in;
      rsp_word_in.motor_position = position_in;
      rsp_word_in.motor_speed    = speed_in;
      if (!advance) begin
         status_in   = status_ff;
         position_in = position_ff;
         speed_in    = speed_ff;
         rsp_word_in = rsp_word_ff;
      end

      // Drop the result once taken, unless a new one replaces it
      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_READY;
         position_ff  <= 32'h0;
         speed_ff     <= 32'h0;
         node_id_ff   <= NODE_ID_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         position_ff  <= position_in;
         speed_ff     <= speed_in;
         node_id_ff   <= node_id_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for sdo_motor_client_unit: directed table, then random words.
// Depends on sdomc_pkg for the word types, command kinds, SDO codes and indices.
module testbench
   import sdomc_pkg::*;
();

   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         PHASE_COUNT   = 5;
   localparam int         PHASE_WORDS   = 270;
   localparam logic [3:0] KIND_UNUSED   = 4'd15;   // no frame, state untouched

   // Pools for well-formed received frames
   localparam logic [7:0]  REPLY_CS [6] = '{CS_WR_ACK, CS_RD_1B, CS_RD_2B, CS_RD_3B,
                                            CS_RD_4B, CS_ABORT};
   localparam logic [15:0] OBJ_IDX [13] = '{IDX_SAVE, IDX_CTRL_TYPE, IDX_SPEED,
                                            IDX_POS_TYPE, IDX_TARGET, IDX_MAX_SPEED,
                                            IDX_SPD_UNIT, IDX_ACC_UNIT, IDX_RESET_POS,
                                            IDX_POSITION, IDX_RD_SPEED, IDX_LOCKED,
                                            IDX_FAULT};

   typedef struct {
      req_word_type word;
      bit           typed;   // expected reply typed in below, predictor bypassed
      rsp_word_type reply;
   } stim_row_type;

   // Block ports
   logic         clock          = 1'b0;
   logic         reset          = 1'b1;
   logic         req_valid      = 1'b0;
   logic         req_stall;
   req_word_type req_word       = '0;
   logic         rsp_valid;
   logic         rsp_stall      = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_en   = 1'b0;
   logic [6:0]   csr_write_data = '0;

   // Predicted motor state and node id
   logic [1:0]  link_q = ST_READY;
   logic [31:0] pos_q  = '0;
   logic [31:0] spd_q  = '0;
   logic [6:0]  node_q = NODE_ID_RESET;

   rsp_word_type reply_q [$];       // expected replies, oldest first
   stim_row_type directed_rows [$];

   // Hand-over from the sender to the monitor for the word on offer
   bit           cur_typed = 1'b0;
   rsp_word_type cur_reply = '0;

   // Idling control
   bit send_quiet      = 1'b0;
   bit recv_quiet      = 1'b0;
   int burst_left      = 0;
   int rsp_hold_cycles = 0;

   int cycle_count  = 0;
   int fail_count   = 0;
   int words_in     = 0;
   int frames_built = 0;
   int frames_seen  = 0;
   int aborts_seen  = 0;

   sdo_motor_client_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Frame layout: command byte, index little-endian, subindex, data little-endian
   function automatic logic [63:0] frame_of(input logic [7:0] cs, input logic [15:0] idx,
                                            input logic [7:0] sub, input logic [31:0] data);
      return {data, sub, idx, cs};
   endfunction

   function automatic req_word_type make_req(input logic rt, input logic [3:0] kind,
                                             input logic [31:0] val, input logic [63:0] rx);
      req_word_type w;
      w.req_type  = rt;
      w.cmd_kind  = kind;
      w.cmd_value = val;
      w.rx_frame  = rx;
      return w;
   endfunction

   function automatic rsp_word_type make_reply(input logic txv, input logic [10:0] id,
                                               input logic [63:0] tx, input logic [1:0] st,
                                               input logic [31:0] pos, input logic [31:0] spd,
                                               input logic [31:0] code, input logic seen);
      rsp_word_type r;
      r.tx_valid       = txv;
      r.tx_can_id      = id;
      r.tx_data        = tx;
      r.link_status    = st;
      r.motor_position = pos;
      r.motor_speed    = spd;
      r.abort_code     = code;
      r.abort_seen     = seen;
      return r;
   endfunction

   function automatic void add_row(input req_word_type w, input bit typed = 1'b0,
                                   input rsp_word_type r = '0);
      stim_row_type row;
      row.word  = w;
      row.typed = typed;
      row.reply = r;
      directed_rows.push_back(row);
   endfunction

   // Work out the reply to one word and advance the predicted state
   function automatic rsp_word_type predict_reply(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  val;
      logic [31:0]  rd;
      logic [7:0]   cs;
      logic [15:0]  idx;
      r   = '0;
      val = w.cmd_value;
      cs  = w.rx_frame[7:0];
      idx = w.rx_frame[23:8];
      rd  = w.rx_frame[63:32];
      if (w.req_type == REQ_SEND) begin
         r.tx_valid = 1'b1;
         case (w.cmd_kind)
            KIND_SAVE:       r.tx_data = frame_of(CS_WRITE_4B, IDX_SAVE, SUB_SAVE, SAVE_MAGIC);
            KIND_CTRL_TYPE:  r.tx_data = frame_of(CS_WRITE_1B, IDX_CTRL_TYPE, '0,
                                                  {24'd0, val[7:0]});
            KIND_ACCEL_UNIT: r.tx_data = frame_of(CS_WRITE_1B, IDX_ACC_UNIT, '0,
                                                  {24'd0, val[7:0]});
            KIND_SPEED_UNIT: r.tx_data = frame_of(CS_WRITE_1B, IDX_SPD_UNIT, '0,
                                                  {24'd0, val[7:0]});
            KIND_MAX_SPEED:  r.tx_data = frame_of(CS_WRITE_4B, IDX_MAX_SPEED, '0,
                                                  {16'd0, val[15:0]});
            KIND_SPEED: begin
               r.tx_data = frame_of(CS_WRITE_4B, IDX_SPEED, '0, val);
               spd_q     = val;
            end
            KIND_POS_TYPE:   r.tx_data = frame_of(CS_WRITE_1B, IDX_POS_TYPE, '0,
                                                  {24'd0, val[7:0]});
            KIND_RESET_POS: begin
               r.tx_data = frame_of(CS_WRITE_4B, IDX_RESET_POS, '0, '0);
               pos_q     = '0;
            end
            KIND_TARGET:     r.tx_data = frame_of(CS_WRITE_4B, IDX_TARGET, '0, val);
            KIND_RD_FAULT:   r.tx_data = frame_of(CS_READ, IDX_FAULT, '0, '0);
            KIND_RD_LOCKED:  r.tx_data = frame_of(CS_READ, IDX_LOCKED, '0, '0);
            KIND_RD_SPEED:   r.tx_data = frame_of(CS_READ, IDX_RD_SPEED, '0, '0);
            KIND_RD_POS:     r.tx_data = frame_of(CS_READ, IDX_POSITION, '0, '0);
            default:         r.tx_valid = 1'b0;
         endcase
         if (r.tx_valid) begin
            r.tx_can_id = TX_ID_BASE + {4'd0, node_q};
            link_q      = ST_READY;
         end
      end else begin
         case (cs)
            CS_WR_ACK: begin
               case (idx)
                  IDX_SAVE: if (w.rx_frame[31:24] == SUB_SAVE) link_q = ST_READY;
                  IDX_CTRL_TYPE, IDX_SPEED, IDX_POS_TYPE, IDX_TARGET, IDX_MAX_SPEED,
                  IDX_SPD_UNIT, IDX_ACC_UNIT, IDX_RESET_POS: link_q = ST_READY;
                  default: link_q = ST_ERROR;
               endcase
            end
            CS_RD_1B, CS_RD_2B, CS_RD_3B, CS_RD_4B: begin
               // zero-extend the bytes the command byte announces
               case (cs)
                  CS_RD_1B: rd = rd & 32'h0000_00FF;
                  CS_RD_2B: rd = rd & 32'h0000_FFFF;
                  CS_RD_3B: rd = rd & 32'h00FF_FFFF;
                  default:  rd = rd;
               endcase
               case (idx)
                  IDX_POSITION: begin
                     pos_q  = rd;
                     link_q = ST_READY;
                  end
                  IDX_RD_SPEED: begin
                     spd_q  = rd;
                     link_q = ST_READY;
                  end
                  IDX_LOCKED: if (rd != 0) link_q = ST_LOCKED;
                  IDX_FAULT:  if (rd != 0) link_q = ST_FAULT;
                  default:    link_q = ST_ERROR;
               endcase
            end
            CS_ABORT: begin
               link_q       = ST_ERROR;
               r.abort_code = w.rx_frame[63:32];
               r.abort_seen = 1'b1;
            end
            default: link_q = ST_ERROR;
         endcase
      end
      r.link_status    = link_q;
      r.motor_position = pos_q;
      r.motor_speed    = spd_q;
      return r;
   endfunction

   // Lean towards the signed extremes and zero
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed SDO traffic with random content, some raw noise
   function automatic req_word_type random_word();
      req_word_type w;
      logic [7:0]   cs;
      logic [15:0]  idx;
      logic [7:0]   sub;
      w.req_type  = 1'($urandom_range(0, 1));
      w.cmd_kind  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
      w.cmd_value = pick_value();
      w.rx_frame  = {$urandom, $urandom};
      if (w.req_type == REQ_DECODE && $urandom_range(0, 9) != 0) begin
         cs  = REPLY_CS[$urandom_range(0, 5)];
         idx = ($urandom_range(0, 15) == 0) ? 16'($urandom) : OBJ_IDX[$urandom_range(0, 12)];
         sub = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SUB_SAVE;
         w.rx_frame = frame_of(cs, idx, sub, ($urandom_range(0, 3) == 0) ? '0 : pick_value());
      end
      return w;
   endfunction

   // Offer one word, idling first as drawn; return at the falling edge after acceptance
   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type r);
      int gap;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = send_quiet ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= w;
      cur_typed  = typed;
      cur_reply  = r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Hold until every expected reply has arrived, then let the pipeline settle
   task automatic drain_replies();
      while (reply_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Monitor: predict on each accepted word, compare each accepted reply
   always @(posedge clock) begin
      rsp_word_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_reply(req_word);
            if (cur_typed) want = cur_reply;
            reply_q.push_back(want);
            words_in++;
            if (want.tx_valid) frames_built++;
            if (req_word.req_type == REQ_DECODE) frames_seen++;
            if (want.abort_seen) aborts_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               $error("reply with no word outstanding: %h", rsp_word);
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_word.tx_valid !== want.tx_valid) begin
                  $error("tx_valid: expected %h, got %h", want.tx_valid, rsp_word.tx_valid);
                  fail_count++;
               end
               if (rsp_word.tx_can_id !== want.tx_can_id) begin
                  $error("tx_can_id: expected %h, got %h", want.tx_can_id, rsp_word.tx_can_id);
                  fail_count++;
               end
               if (rsp_word.tx_data !== want.tx_data) begin
                  $error("tx_data: expected %h, got %h", want.tx_data, rsp_word.tx_data);
                  fail_count++;
               end
               if (rsp_word.link_status !== want.link_status) begin
                  $error("link_status: expected %h, got %h",
                         want.link_status, rsp_word.link_status);
                  fail_count++;
               end
               if (rsp_word.motor_position !== want.motor_position) begin
                  $error("motor_position: expected %h, got %h",
                         want.motor_position, rsp_word.motor_position);
                  fail_count++;
               end
               if (rsp_word.motor_speed !== want.motor_speed) begin
                  $error("motor_speed: expected %h, got %h",
                         want.motor_speed, rsp_word.motor_speed);
                  fail_count++;
               end
               if (rsp_word.abort_code !== want.abort_code) begin
                  $error("abort_code: expected %h, got %h", want.abort_code, rsp_word.abort_code);
                  fail_count++;
               end
               if (rsp_word.abort_seen !== want.abort_seen) begin
                  $error("abort_seen: expected %h, got %h", want.abort_seen, rsp_word.abort_seen);
                  fail_count++;
               end
            end
         end
         // Node id takes effect at the same edge as in the block
         if (csr_write_en) node_q = csr_write_data;
      end
   end

   // Receiver: stall for a drawn count before each reply, or for a requested hold-off
   initial begin
      int pause;
      forever begin
         if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
         if (rsp_hold_cycles > 0) begin
            pause           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            pause = recv_quiet ? 0 : $urandom_range(0, 15);
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Sender and sequencing
   initial begin
      logic [6:0] node_pick;
      int         phase;
      int         n;

      // Directed table; typed replies assume reset state and node 9
      add_row(make_req(REQ_SEND, KIND_SAVE, '0, '0), 1'b1,
              make_reply(1'b1, TX_ID_BASE + 11'(NODE_ID_RESET),
                         frame_of(CS_WRITE_4B, IDX_SAVE, SUB_SAVE, SAVE_MAGIC),
                         ST_READY, '0, '0, '0, 1'b0));
      add_row(make_req(REQ_SEND, KIND_SPEED, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
              make_reply(1'b1, TX_ID_BASE + 11'(NODE_ID_RESET),
                         frame_of(CS_WRITE_4B, IDX_SPEED, '0, 32'h7FFF_FFFF),
                         ST_READY, '0, 32'h7FFF_FFFF, '0, 1'b0));
      add_row(make_req(REQ_SEND, KIND_SPEED, 32'h8000_0000, '0), 1'b1,
              make_reply(1'b1, TX_ID_BASE + 11'(NODE_ID_RESET),
                         frame_of(CS_WRITE_4B, IDX_SPEED, '0, 32'h8000_0000),
                         ST_READY, '0, 32'h8000_0000, '0, 1'b0));
      // abort with an all-ones code
      add_row(make_req(REQ_DECODE, KIND_UNUSED, 32'hFFFF_FFFF,
                       frame_of(CS_ABORT, IDX_SPEED, 8'hFF, 32'hFFFF_FFFF)), 1'b1,
              make_reply(1'b0, '0, '0, ST_ERROR, '0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
      add_row(make_req(REQ_SEND, KIND_CTRL_TYPE, 32'hFFFF_FFFF, '0));
      add_row(make_req(REQ_SEND, KIND_ACCEL_UNIT, 32'h1234_5678, '0));
      add_row(make_req(REQ_SEND, KIND_SPEED_UNIT, 32'h0000_00A5, '0));
      add_row(make_req(REQ_SEND, KIND_MAX_SPEED, 32'hFFFF_FFFF, '0));
      add_row(make_req(REQ_SEND, KIND_POS_TYPE, 32'h8000_0080, '0));
      add_row(make_req(REQ_SEND, KIND_TARGET, 32'h8000_0000, '0));
      add_row(make_req(REQ_SEND, KIND_RD_FAULT, '0, '0));
      add_row(make_req(REQ_SEND, KIND_RD_LOCKED, '0, '0));
      add_row(make_req(REQ_SEND, KIND_RD_SPEED, '0, '0));
      add_row(make_req(REQ_SEND, KIND_RD_POS, '0, '0));
      // unknown command byte, then an unknown kind that leaves the error standing
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, '0), 1'b1,
              make_reply(1'b0, '0, '0, ST_ERROR, '0, 32'h8000_0000, '0, 1'b0));
      add_row(make_req(REQ_SEND, KIND_UNUSED, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b1,
              make_reply(1'b0, '0, '0, ST_ERROR, '0, 32'h8000_0000, '0, 1'b0));
      // save acknowledge: wrong subindex keeps the status, right one clears it
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_WR_ACK, IDX_SAVE, 8'h02, '0)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_WR_ACK, IDX_SAVE, SUB_SAVE, '0)));
      // read responses of each length; bytes past the length must be dropped
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0,
                       frame_of(CS_RD_4B, IDX_POSITION, '0, 32'hFFFF_FFFF)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0,
                       frame_of(CS_RD_1B, IDX_RD_SPEED, '0, 32'hDEAD_BEEF)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0,
                       frame_of(CS_RD_2B, IDX_LOCKED, '0, 32'hFFFF_0000)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0,
                       frame_of(CS_RD_3B, IDX_LOCKED, '0, 32'h0001_0000)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_RD_1B, IDX_FAULT, '0, 32'h1)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_WR_ACK, 16'hFFFF, '0, '0)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_RD_4B, 16'h2106, '0, 32'h5)));
      add_row(make_req(REQ_SEND, KIND_RESET_POS, 32'hFFFF_FFFF, '0));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_ABORT, IDX_TARGET, '0, '0)));
      add_row(make_req(REQ_DECODE, KIND_SAVE, '0, frame_of(CS_WR_ACK, IDX_TARGET, '0, '0)));

      // Hold reset, then release it on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);
      req_valid <= 1'b0;
      drain_replies();

      // Random phases, each under its own node id: the extremes first
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       node_pick = 7'd127;
            1:       node_pick = 7'd0;
            default: node_pick = 7'($urandom_range(1, 126));
         endcase
         csr_write_en   <= 1'b1;
         csr_write_data <= node_pick;
         @(negedge clock);
         csr_write_en   <= 1'b0;

         // Back-pressure: long receiver hold-off against a back-to-back sender
         if (phase == 0) begin
            rsp_hold_cycles = 80;
            burst_left      = 40;
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            // Pause the sender mid-phase until the block has fully drained
            if (phase == 2 && n == PHASE_WORDS / 2) begin
               req_valid <= 1'b0;
               drain_replies();
            end
            send_word(random_word(), 1'b0, '0);
         end
         req_valid <= 1'b0;
         drain_replies();
      end

      $display("Covered %0d words: %0d request frames built, %0d received frames decoded, %0d aborts",
               words_in, frames_built, frames_seen, aborts_seen);
      $display("Node ids 9, 127, 0 and %0d random settings; %0d field mismatches",
               PHASE_COUNT - 2, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
